// ===== rtl/core/gray_tone_curve_adjust_core_macros.svh =====
// Assertion helpers for the tone curve core.
// Each check is sampled on clk_i and switched off while rst_ni is low.
`ifndef GRAY_TONE_CURVE_ADJUST_CORE_MACROS_SVH
`define GRAY_TONE_CURVE_ADJUST_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define GTCA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("gtca check failed");
`define GTCA_ASSERT_IMPLIES(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("gtca check failed");
`else
`define GTCA_ASSERT(lbl, prop)
`define GTCA_ASSERT_IMPLIES(lbl, pre, post)
`endif
`endif

// ===== rtl/core/gtca_pkg.sv =====
package gtca_pkg;

  // Pass and accumulator limits
  localparam int MaxPixels = 65536;
  localparam int CntW      = $clog2(MaxPixels + 1);
  localparam int TotalW    = 24;

  // Fixed point constants
  localparam logic [15:0] Mid127  = 16'd32512;
  localparam logic [15:0] Mid255  = 16'd65280;
  localparam logic [21:0] UnitQ14 = 22'd4177920;

  // Shared divider widths
  localparam int DivNumW = 52;
  localparam int DivDenW = 36;
  localparam int DivCntW = $clog2(DivNumW);

  // Request queue
  localparam int QueueDepth = 4;
  localparam int QPtrW      = $clog2(QueueDepth);

  localparam logic OpMeasure = 1'b0;

  typedef enum logic [2:0] {
    CFG_ADJ_EN   = 3'd0,
    CFG_AUTO_MID = 3'd1,
    CFG_MIDPOINT = 3'd2,
    CFG_BRIGHT   = 3'd3,
    CFG_CONTRAST = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ITEM_MEASURE = 2'd0,
    ITEM_ADJUST  = 2'd1,
    ITEM_BYPASS  = 2'd2
  } item_kind_e;

  typedef struct packed {
    logic               adjust_enable;
    logic               auto_midpoint;
    logic [7:0]         midpoint;
    logic signed [15:0] brightness;
    logic signed [15:0] contrast;
  } cfg_t;

  typedef struct packed {
    item_kind_e kind;
    logic [7:0] gray;
    logic [7:0] alpha;
    logic       last;
  } item_t;

  typedef struct packed {
    logic        pixel_valid;
    logic [7:0]  gray;
    logic [7:0]  alpha;
    logic        estimate_valid;
    logic [15:0] mid;
    logic        last;
  } result_t;

  typedef struct packed {
    logic               start;
    logic [DivNumW-1:0] num;
    logic [DivDenW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [31:0] quot;
  } div_rsp_t;

  // Clamp a raw Q1.14 value to minus one .. one
  function automatic logic signed [15:0] q14_clamp(input logic signed [15:0] raw);
    logic signed [15:0] v;
    v = raw;
    if (raw > 16'sd16384) v = 16'sd16384;
    if (raw < -16'sd16384) v = -16'sd16384;
    return v;
  endfunction

endpackage

// ===== rtl/core/gtca_front.sv =====
module gtca_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic            operation_i,
  input  logic [7:0]      alpha_in_i,
  input  logic [7:0]      red_in_i,
  input  logic [7:0]      green_in_i,
  input  logic [7:0]      blue_in_i,
  input  logic            last_pixel_i,
  input  logic            adjust_enable_i,
  input  logic            pop_i,
  output logic            item_valid_o,
  output gtca_pkg::item_t item_o
);
  import gtca_pkg::*;

  item_t            mem_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPtrW:0]   count_q;
  logic [12:0]      gray_sum;
  item_t            new_item;
  logic             push, pop;

  // Convert to gray and classify the request
  always_comb begin
    gray_sum = 13'({5'd0, red_in_i} * 13'd11) + 13'({5'd0, green_in_i} * 13'd16)
             + 13'({5'd0, blue_in_i} * 13'd5);
    new_item.gray  = gray_sum[12:5];
    new_item.alpha = alpha_in_i;
    new_item.last  = last_pixel_i;
    if (operation_i == OpMeasure) begin
      new_item.kind = ITEM_MEASURE;
    end else if (adjust_enable_i) begin
      new_item.kind = ITEM_ADJUST;
    end else begin
      new_item.kind = ITEM_BYPASS;
    end
  end

  assign in_ready_o   = (count_q != (QPtrW + 1)'(QueueDepth));
  assign item_valid_o = (count_q != '0);
  assign item_o       = mem_q[rd_ptr_q];
  assign push         = in_valid_i && in_ready_o;
  assign pop          = pop_i && item_valid_o;

  // Advance queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // Hold queued requests
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= new_item;
  end

endmodule

// ===== rtl/core/gtca_div.sv =====
module gtca_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  gtca_pkg::div_req_t req_i,
  output gtca_pkg::div_rsp_t rsp_o
);
  import gtca_pkg::*;

  logic [DivNumW-1:0] num_q, quo_q;
  logic [DivDenW-1:0] den_q, rem_q;
  logic [DivCntW-1:0] cnt_q;
  logic               busy_q, done_q;
  logic [DivDenW:0]   rem_sh, rem_sub;
  logic               fits;

  // One restoring step per cycle
  always_comb begin
    rem_sh  = {rem_q, num_q[DivNumW-1]};
    rem_sub = rem_sh - {1'b0, den_q};
    fits    = (rem_sh >= {1'b0, den_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= DivCntW'(DivNumW - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start && !busy_q) begin
      num_q <= req_i.num;
      den_q <= req_i.den;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[DivNumW-2:0], 1'b0};
      rem_q <= fits ? rem_sub[DivDenW-1:0] : rem_sh[DivDenW-1:0];
      quo_q <= {quo_q[DivNumW-2:0], fits};
    end
  end

  // Saturate the quotient to 32 bits
  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = (|quo_q[DivNumW-1:32]) ? 32'hFFFF_FFFF : quo_q[31:0];

endmodule

// ===== rtl/core/gtca_back.sv =====
module gtca_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  gtca_pkg::cfg_t     cfg_i,
  input  logic               item_valid_i,
  input  gtca_pkg::item_t    item_i,
  output logic               pop_o,
  output gtca_pkg::div_req_t div_req_o,
  input  gtca_pkg::div_rsp_t div_rsp_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output gtca_pkg::result_t  out_o
);
  import gtca_pkg::*;

  typedef enum logic [11:0] {
    ST_IDLE  = 12'b0000_0000_0001,
    ST_ACC   = 12'b0000_0000_0010,
    ST_EST   = 12'b0000_0000_0100,
    ST_EWAIT = 12'b0000_0000_1000,
    ST_CURVE = 12'b0000_0001_0000,
    ST_LDIV  = 12'b0000_0010_0000,
    ST_LWAIT = 12'b0000_0100_0000,
    ST_HDIV  = 12'b0000_1000_0000,
    ST_HWAIT = 12'b0001_0000_0000,
    ST_MAP   = 12'b0010_0000_0000,
    ST_ROUND = 12'b0100_0000_0000,
    ST_EMIT  = 12'b1000_0000_0000
  } state_e;

  state_e              state_q, state_d;
  logic [TotalW-1:0]   light_q, light_d, atot_q, atot_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [15:0]         est_q, est_d;
  logic [31:0]         lslope_q, lslope_d, hslope_q, hslope_d;
  logic [21:0]         loff_q, loff_d, hoff_q, hoff_d;
  logic                ready_q, ready_d;
  logic                outv_q, outv_d;
  item_t               item_q, item_d;
  result_t             res_q, res_d, out_q, out_d;
  logic                neutral_q, neutral_d;
  logic [15:0]         mid_q, mid_d;
  logic [21:0]         my_q, my_d;
  logic signed [15:0]  c_q, c_d;
  logic signed [50:0]  prod_q, prod_d;
  logic                hi_q, hi_d;

  logic [15:0]         wprod;
  logic [16:0]         wsum;
  logic [TotalW:0]     lsum, asum;
  logic signed [15:0]  b_cl, c_cl;
  logic [15:0]         mx;
  logic signed [16:0]  diff;
  logic signed [23:0]  my_s;
  logic [21:0]         rise;
  logic [15:0]         run;
  logic [15:0]         kdiff, ksum;
  logic [29:0]         den_pos;
  logic [36:0]         num_neg;
  logic [DivDenW-1:0]  sden;
  logic [DivNumW-1:0]  snum;
  logic signed [17:0]  dlt;
  logic signed [51:0]  acc, rnd;
  logic [29:0]         rsh;
  logic [7:0]          mapped;

  // Pixel weight: round(gray * alpha / 255) through a reciprocal trick
  always_comb begin
    wprod = 16'({8'd0, item_q.gray} * {8'd0, item_q.alpha}) + 16'd127;
    wsum  = {1'b0, wprod} + {9'd0, wprod[15:8]} + 17'd1;
    lsum  = {1'b0, light_q} + (TotalW + 1)'(wsum[15:8]);
    asum  = {1'b0, atot_q} + (TotalW + 1)'(item_q.alpha);
  end

  // Curve parameters from the live registers
  always_comb begin
    b_cl = q14_clamp(cfg_i.brightness);
    c_cl = q14_clamp(cfg_i.contrast);
    mx   = cfg_i.auto_midpoint ? est_q : {cfg_i.midpoint, 8'd0};
    diff = $signed({1'b0, mx}) - $signed({1'b0, Mid127});
    if (b_cl > 16'sd0) begin
      my_s = 24'sd2080768 + ({{8{b_cl[15]}}, b_cl} <<< 7);
    end else begin
      my_s = 24'sd2080768 + ({{8{b_cl[15]}}, b_cl} <<< 7) - {{8{b_cl[15]}}, b_cl};
    end
  end

  // Slope division operands, rounded half up
  always_comb begin
    if (state_q == ST_HDIV) begin
      rise = UnitQ14 - my_q;
      run  = Mid255 - mid_q;
    end else begin
      rise = my_q;
      run  = mid_q;
    end
    kdiff   = 16'(16'sd16384 - c_q);
    ksum    = 16'(c_q + 16'sd16384);
    den_pos = 30'({16'd0, kdiff[13:0]} * {14'd0, run});
    num_neg = 37'({15'd0, rise} * {22'd0, ksum[14:0]});
    if (c_q > 16'sd0) begin
      sden = DivDenW'(den_pos);
      snum = DivNumW'({rise, 22'd0}) + DivNumW'(sden >> 1);
    end else begin
      sden = {run, 20'd0};
      snum = DivNumW'({num_neg, 14'd0}) + DivNumW'(sden >> 1);
    end
  end

  // Divider request
  always_comb begin
    div_req_o.start = 1'b0;
    div_req_o.num   = snum;
    div_req_o.den   = sden;
    if (state_q == ST_EST) begin
      div_req_o.start = (atot_q != '0);
      div_req_o.num   = DivNumW'({16'd0, light_q} * {24'd0, Mid255})
                      + DivNumW'(atot_q >> 1);
      div_req_o.den   = DivDenW'(atot_q);
    end else if (state_q == ST_LDIV) begin
      div_req_o.start = (mid_q != '0);
    end else if (state_q == ST_HDIV) begin
      div_req_o.start = (mid_q < Mid255);
    end
  end

  // Segment product and final rounding
  always_comb begin
    dlt    = $signed({2'b0, item_q.gray, 8'd0}) - $signed({2'b0, mid_q});
    hi_d   = !dlt[17];
    prod_d = $signed({1'b0, (hi_d ? hslope_q : lslope_q)}) * dlt;
    acc    = $signed({22'd0, (hi_q ? hoff_q : loff_q), 8'd0}) + {prod_q[50], prod_q};
    rnd    = acc + 52'sd2097152;
    rsh    = rnd[51:22];
    if (neutral_q) begin
      mapped = item_q.gray;
    end else if (acc[51]) begin
      mapped = 8'd0;
    end else if (|rsh[29:8]) begin
      mapped = 8'hFF;
    end else begin
      mapped = rsh[7:0];
    end
  end

  assign pop_o = (state_q == ST_IDLE) && item_valid_i;

  // Sequencer
  always_comb begin
    state_d   = state_q;
    light_d   = light_q;
    atot_d    = atot_q;
    cnt_d     = cnt_q;
    est_d     = est_q;
    lslope_d  = lslope_q;
    hslope_d  = hslope_q;
    loff_d    = loff_q;
    hoff_d    = hoff_q;
    ready_d   = ready_q;
    item_d    = item_q;
    res_d     = res_q;
    neutral_d = neutral_q;
    mid_d     = mid_q;
    my_d      = my_q;
    c_d       = c_q;
    out_d     = out_q;
    outv_d    = outv_q && !out_ready_i;

    unique case (state_q)
      ST_IDLE: begin
        if (item_valid_i) begin
          item_d = item_i;
          res_d  = '0;
          res_d.alpha = item_i.alpha;
          res_d.last  = item_i.last;
          unique case (item_i.kind)
            ITEM_MEASURE: state_d = ST_ACC;
            ITEM_ADJUST:  state_d = ready_q ? ST_MAP : ST_CURVE;
            default: begin
              if (item_i.last) ready_d = 1'b0;
              state_d = ST_EMIT;
            end
          endcase
        end
      end
      ST_ACC: begin
        if (cnt_q < CntW'(MaxPixels)) begin
          cnt_d   = cnt_q + 1'b1;
          light_d = lsum[TotalW] ? '1 : lsum[TotalW-1:0];
          atot_d  = asum[TotalW] ? '1 : asum[TotalW-1:0];
        end
        state_d = item_q.last ? ST_EST : ST_IDLE;
      end
      ST_EST: begin
        if (atot_q == '0) begin
          est_d   = '0;
          light_d = '0;
          atot_d  = '0;
          cnt_d   = '0;
          res_d   = '0;
          res_d.estimate_valid = 1'b1;
          res_d.last = 1'b1;
          state_d = ST_EMIT;
        end else begin
          state_d = ST_EWAIT;
        end
      end
      ST_EWAIT: begin
        if (div_rsp_i.done) begin
          est_d   = (|div_rsp_i.quot[31:16]) ? 16'hFFFF : div_rsp_i.quot[15:0];
          light_d = '0;
          atot_d  = '0;
          cnt_d   = '0;
          res_d   = '0;
          res_d.estimate_valid = 1'b1;
          res_d.mid  = est_d;
          res_d.last = 1'b1;
          state_d = ST_EMIT;
        end
      end
      ST_CURVE: begin
        mid_d     = mx;
        neutral_d = (diff < 17'sd26) && (diff > -17'sd26) && (b_cl == 16'sd0)
                    && (c_cl == 16'sd0);
        my_d      = my_s[21:0];
        c_d       = c_cl;
        lslope_d  = '0;
        hslope_d  = '0;
        ready_d   = 1'b1;
        if (c_cl >= 16'sd16384) begin
          loff_d  = '0;
          hoff_d  = UnitQ14;
          state_d = ST_MAP;
        end else begin
          loff_d  = my_s[21:0];
          hoff_d  = (mx >= Mid255) ? UnitQ14 : my_s[21:0];
          state_d = ST_LDIV;
        end
      end
      ST_LDIV: state_d = (mid_q != '0) ? ST_LWAIT : ST_HDIV;
      ST_LWAIT: begin
        if (div_rsp_i.done) begin
          lslope_d = div_rsp_i.quot;
          state_d  = ST_HDIV;
        end
      end
      ST_HDIV: state_d = (mid_q < Mid255) ? ST_HWAIT : ST_MAP;
      ST_HWAIT: begin
        if (div_rsp_i.done) begin
          hslope_d = div_rsp_i.quot;
          state_d  = ST_MAP;
        end
      end
      ST_MAP: state_d = ST_ROUND;
      ST_ROUND: begin
        res_d.pixel_valid = 1'b1;
        res_d.gray = mapped;
        if (item_q.last) ready_d = 1'b0;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (!outv_q || out_ready_i) begin
          out_d   = res_q;
          outv_d  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control and running state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      light_q  <= '0;
      atot_q   <= '0;
      cnt_q    <= '0;
      est_q    <= Mid127;
      lslope_q <= '0;
      hslope_q <= '0;
      loff_q   <= '0;
      hoff_q   <= '0;
      ready_q  <= 1'b0;
      outv_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      light_q  <= light_d;
      atot_q   <= atot_d;
      cnt_q    <= cnt_d;
      est_q    <= est_d;
      lslope_q <= lslope_d;
      hslope_q <= hslope_d;
      loff_q   <= loff_d;
      hoff_q   <= hoff_d;
      ready_q  <= ready_d;
      outv_q   <= outv_d;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    item_q    <= item_d;
    res_q     <= res_d;
    out_q     <= out_d;
    neutral_q <= neutral_d;
    mid_q     <= mid_d;
    my_q      <= my_d;
    c_q       <= c_d;
    prod_q    <= prod_d;
    hi_q      <= hi_d;
  end

  assign out_valid_o = outv_q;
  assign out_o       = out_q;

endmodule

// ===== rtl/core/gray_tone_curve_adjust_core.sv =====
// Gray tone curve core for ARGB brush tips.
// Input channel (in_valid_i/in_ready_o): one pixel per request with an
// operation bit; measure requests sum weighted gray, the last one yields a
// Q8.8 midpoint result; adjust requests yield one gray result each.
// Output channel (out_valid_o/out_ready_i): one result per adjust request and
// per final measure request; other measure requests yield nothing.
// Configuration: write cfg_data_i to register cfg_idx_i while cfg_we_i is high,
// only while the core is idle.
// Sequencing: the back end takes one request at a time. A measure request is
// accumulated; the final one then runs the estimate on the 52-step shared
// divider. An adjust request is mapped, rounded and emitted, the first of a
// pass after a curve build of up to two slope divisions; bypass is emitted.
// A four-deep request queue lets input keep arriving while the back end works
// or the output register waits on a stalled receiver.
// Reset clears the queue, totals, curve and output valid, and sets the held
// midpoint to 127.0 and the midpoint register to 127.
`include "gray_tone_curve_adjust_core_macros.svh"
module gray_tone_curve_adjust_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        operation_i,
  input  logic [7:0]  alpha_in_i,
  input  logic [7:0]  red_in_i,
  input  logic [7:0]  green_in_i,
  input  logic [7:0]  blue_in_i,
  input  logic        last_pixel_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        pixel_valid_o,
  output logic [7:0]  gray_out_o,
  output logic [7:0]  alpha_out_o,
  output logic        estimate_valid_o,
  output logic [15:0] measured_mid_o,
  output logic        last_out_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);
  import gtca_pkg::*;

  cfg_t     cfg_q;
  logic     item_valid, pop;
  item_t    item;
  div_req_t div_req;
  div_rsp_t div_rsp;
  result_t  res;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.adjust_enable <= 1'b0;
      cfg_q.auto_midpoint <= 1'b0;
      cfg_q.midpoint      <= 8'd127;
      cfg_q.brightness    <= '0;
      cfg_q.contrast      <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ADJ_EN:   cfg_q.adjust_enable <= cfg_data_i[0];
        CFG_AUTO_MID: cfg_q.auto_midpoint <= cfg_data_i[0];
        CFG_MIDPOINT: cfg_q.midpoint      <= cfg_data_i[7:0];
        CFG_BRIGHT:   cfg_q.brightness    <= cfg_data_i;
        CFG_CONTRAST: cfg_q.contrast      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  gtca_front u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .operation_i,
    .alpha_in_i,
    .red_in_i,
    .green_in_i,
    .blue_in_i,
    .last_pixel_i,
    .adjust_enable_i (cfg_q.adjust_enable),
    .pop_i           (pop),
    .item_valid_o    (item_valid),
    .item_o          (item)
  );

  gtca_div u_div (
    .clk_i,
    .rst_ni,
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  gtca_back u_back (
    .clk_i,
    .rst_ni,
    .cfg_i        (cfg_q),
    .item_valid_i (item_valid),
    .item_i       (item),
    .pop_o        (pop),
    .div_req_o    (div_req),
    .div_rsp_i    (div_rsp),
    .out_valid_o,
    .out_ready_i,
    .out_o        (res)
  );

  assign pixel_valid_o    = res.pixel_valid;
  assign gray_out_o       = res.gray;
  assign alpha_out_o      = res.alpha;
  assign estimate_valid_o = res.estimate_valid;
  assign measured_mid_o   = res.mid;
  assign last_out_o       = res.last;

  // Checks
  `GTCA_ASSERT(a_one_kind, !(out_valid_o && pixel_valid_o && estimate_valid_o))
  `GTCA_ASSERT_IMPLIES(a_est_last, out_valid_o && estimate_valid_o, last_out_o)
  `GTCA_ASSERT_IMPLIES(a_div_free, div_req.start, !div_rsp.busy && !div_rsp.done)

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import gtca_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic        operation_i;
  logic [7:0]  alpha_in_i;
  logic [7:0]  red_in_i;
  logic [7:0]  green_in_i;
  logic [7:0]  blue_in_i;
  logic        last_pixel_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic        pixel_valid_o;
  logic [7:0]  gray_out_o;
  logic [7:0]  alpha_out_o;
  logic        estimate_valid_o;
  logic [15:0] measured_mid_o;
  logic        last_out_o;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [15:0] cfg_data_i;

  typedef struct packed {
    logic       op;
    logic [7:0] a;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic       last;
  } pix_t;

  typedef struct packed {
    logic        pixel_valid;
    logic [7:0]  gray;
    logic [7:0]  alpha;
    logic        estimate_valid;
    logic [15:0] mid;
    logic        last;
  } res_t;

  pix_t pending_pix_q[$];
  res_t expected_res_q[$];
  int   err_cnt;
  int   drive_ok;
  int   quiet_mode;
  bit   feeding;

  // Shadow of the block's registers and state
  logic        m_adj_en, m_auto_mid;
  logic [7:0]  m_midpoint;
  logic [15:0] m_bright, m_contrast;
  longint      m_light_tot, m_alpha_tot, m_est_held, m_pix_cnt;
  longint      m_lo_slope, m_hi_slope, m_lo_off, m_hi_off, m_curve_mid;
  bit          m_curve_ready, m_curve_neutral;

  gray_tone_curve_adjust_core u_top (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint clamp_q14(logic [15:0] raw);
    longint v;
    v = longint'($signed(raw));
    if (v > 16384) v = 16384;
    if (v < -16384) v = -16384;
    return v;
  endfunction

  function automatic longint round_div_sat(longint num, longint den);
    longint q;
    q = (num + den / 2) / den;
    return (q > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : q;
  endfunction

  function automatic longint segment_slope(longint rise, longint run, longint c);
    if (c > 0) return round_div_sat(rise << 22, (16384 - c) * run);
    return round_div_sat((rise * (16384 + c)) << 14, run << 20);
  endfunction

  task automatic build_tone_curve();
    longint b, c, mx, diff, my;
    b = clamp_q14(m_bright);
    c = clamp_q14(m_contrast);
    mx = m_auto_mid ? m_est_held : (longint'(m_midpoint) << 8);
    diff = mx - 32512;
    m_curve_mid = mx;
    m_curve_neutral = diff < 26 && diff > -26 && b == 0 && c == 0;
    my = 127 * 16384 + (b > 0 ? 128 : 127) * b;
    m_lo_slope = 0;
    m_hi_slope = 0;
    if (c >= 16384) begin
      m_lo_off = 0;
      m_hi_off = 255 * 16384;
    end else begin
      m_lo_off = my;
      m_hi_off = my;
      if (mx != 0) m_lo_slope = segment_slope(my, mx, c);
      if (mx >= 65280) m_hi_off = 255 * 16384;
      else m_hi_slope = segment_slope(255 * 16384 - my, 65280 - mx, c);
    end
    m_curve_ready = 1'b1;
  endtask

  function automatic logic [7:0] map_tone(longint gv);
    longint d, acc, r;
    bit hi;
    d = (gv << 8) - m_curve_mid;
    hi = d >= 0;
    acc = ((hi ? m_hi_off : m_lo_off) << 8) + (hi ? m_hi_slope : m_lo_slope) * d;
    if (m_curve_neutral) return gv[7:0];
    if (acc < 0) return 8'd0;
    r = (acc + (64'd1 << 21)) >> 22;
    return (r > 255) ? 8'd255 : r[7:0];
  endfunction

  // Predict the result, if any, of one accepted pixel request
  task automatic predict_tone(pix_t p);
    longint gv, e;
    res_t res;
    gv = (longint'(p.r) * 11 + longint'(p.g) * 16 + longint'(p.b) * 5) >> 5;
    res = '0;
    if (p.op == OpMeasure) begin
      if (m_pix_cnt < MaxPixels) begin
        m_pix_cnt++;
        m_light_tot += (gv * p.a + 127) / 255;
        if (m_light_tot > 24'hFFFFFF) m_light_tot = 24'hFFFFFF;
        m_alpha_tot += p.a;
        if (m_alpha_tot > 24'hFFFFFF) m_alpha_tot = 24'hFFFFFF;
      end
      if (!p.last) return;
      if (m_alpha_tot == 0) m_est_held = 0;
      else begin
        e = (m_light_tot * 65280 + m_alpha_tot / 2) / m_alpha_tot;
        m_est_held = (e > 65535) ? 65535 : e;
      end
      m_light_tot = 0;
      m_alpha_tot = 0;
      m_pix_cnt = 0;
      res.estimate_valid = 1'b1;
      res.mid = m_est_held[15:0];
      res.last = 1'b1;
    end else begin
      res.last = p.last;
      res.alpha = p.a;
      if (m_adj_en) begin
        if (!m_curve_ready) build_tone_curve();
        res.pixel_valid = 1'b1;
        res.gray = map_tone(gv);
      end
      if (p.last) m_curve_ready = 1'b0;
    end
    expected_res_q.push_back(res);
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("ERROR %0t: %s got %0d want %0d", $realtime, what, got, want);
    err_cnt++;
  endtask

  // Drive requests on the falling edge, advance on acceptance
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      drive_ok = 0;
    end else begin
      if (in_valid_i && drive_ok) begin
        void'(pending_pix_q.pop_front());
      end
      if (in_valid_i && !drive_ok) begin
        // hold current request
      end else if (pending_pix_q.size() > 0 && feeding &&
                   (quiet_mode != 0 || $urandom_range(99) >= 34)) begin
        in_valid_i   <= 1'b1;
        operation_i  <= pending_pix_q[0].op;
        alpha_in_i   <= pending_pix_q[0].a;
        red_in_i     <= pending_pix_q[0].r;
        green_in_i   <= pending_pix_q[0].g;
        blue_in_i    <= pending_pix_q[0].b;
        last_pixel_i <= pending_pix_q[0].last;
      end else begin
        in_valid_i <= 1'b0;
      end
      out_ready_i <= (quiet_mode != 0) || ($urandom_range(99) >= 34);
      drive_ok = 0;
    end
  end

  // Sample both channels on the rising edge
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        drive_ok = 1;
        predict_tone(pending_pix_q[0]);
      end
      if (out_valid_o && out_ready_i) begin
        if (expected_res_q.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          want = expected_res_q.pop_front();
          if (pixel_valid_o !== want.pixel_valid)
            report_mismatch("pixel_valid", pixel_valid_o, want.pixel_valid);
          if (gray_out_o !== want.gray) report_mismatch("gray_out", gray_out_o, want.gray);
          if (alpha_out_o !== want.alpha) report_mismatch("alpha_out", alpha_out_o, want.alpha);
          if (estimate_valid_o !== want.estimate_valid)
            report_mismatch("estimate_valid", estimate_valid_o, want.estimate_valid);
          if (measured_mid_o !== want.mid)
            report_mismatch("measured_mid", measured_mid_o, want.mid);
          if (last_out_o !== want.last) report_mismatch("last_out", last_out_o, want.last);
        end
      end
    end
  end

  function automatic pix_t rand_pix(logic op, logic last);
    pix_t p;
    p.op = op;
    p.a = 8'($urandom_range(255));
    p.r = 8'($urandom_range(255));
    p.g = 8'($urandom_range(255));
    p.b = 8'($urandom_range(255));
    p.last = last;
    return p;
  endfunction

  // Queue a measure pass then adjust pixels, which random last flags may split
  task automatic queue_passes(int n_meas, int n_adj, bit skewed);
    pix_t p;
    for (int i = 0; i < n_meas; i++) begin
      p = rand_pix(OpMeasure, i == n_meas - 1);
      if (skewed && ($urandom_range(3) == 0)) p.a = 8'd0;
      pending_pix_q.push_back(p);
    end
    for (int i = 0; i < n_adj; i++) begin
      p = rand_pix(~OpMeasure, i == n_adj - 1);
      if ($urandom_range(9) == 0) p.last = 1'b1;
      pending_pix_q.push_back(p);
    end
  endtask

  // Write one register on the falling edge
  task automatic write_reg(cfg_idx_e idx, logic [15:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_ADJ_EN:   m_adj_en = val[0];
      CFG_AUTO_MID: m_auto_mid = val[0];
      CFG_MIDPOINT: m_midpoint = val[7:0];
      CFG_BRIGHT:   m_bright = val;
      CFG_CONTRAST: m_contrast = val;
      default: ;
    endcase
  endtask

  task automatic set_curve(logic en, logic au, logic [7:0] mid, logic [15:0] br,
                           logic [15:0] ct);
    write_reg(CFG_ADJ_EN, {15'd0, en});
    write_reg(CFG_AUTO_MID, {15'd0, au});
    write_reg(CFG_MIDPOINT, {8'd0, mid});
    write_reg(CFG_BRIGHT, br);
    write_reg(CFG_CONTRAST, ct);
  endtask

  // Feed the queued phase and let it drain before touching registers again
  task automatic drain_phase();
    feeding = 1'b1;
    wait (pending_pix_q.size() == 0 && !in_valid_i);
    wait (expected_res_q.size() == 0);
    repeat (200) @(posedge clk_i);
    feeding = 1'b0;
  endtask

  task automatic put_pix(logic op, logic [7:0] a, logic [7:0] r, logic [7:0] g,
                         logic [7:0] b, logic last);
    pending_pix_q.push_back('{op, a, r, g, b, last});
  endtask

  initial begin
    logic [15:0] br, ct;
    err_cnt = 0;
    quiet_mode = 0;
    feeding = 1'b0;
    in_valid_i = 1'b0;
    operation_i = 1'b0;
    alpha_in_i = '0;
    red_in_i = '0;
    green_in_i = '0;
    blue_in_i = '0;
    last_pixel_i = 1'b0;
    out_ready_i = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_ADJ_EN;
    cfg_data_i = '0;
    m_adj_en = 0; m_auto_mid = 0; m_midpoint = 8'd127; m_bright = '0; m_contrast = '0;
    m_light_tot = 0; m_alpha_tot = 0; m_est_held = 32512; m_pix_cnt = 0;
    m_lo_slope = 0; m_hi_slope = 0; m_lo_off = 0; m_hi_off = 0; m_curve_mid = 0;
    m_curve_ready = 0; m_curve_neutral = 0;
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: bypass, empty alpha, extremes, neutral, threshold, saturation
    put_pix(~OpMeasure, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
    put_pix(OpMeasure, 8'h00, 8'hFF, 8'hFF, 8'hFF, 1'b1);
    put_pix(OpMeasure, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0);
    put_pix(OpMeasure, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
    drain_phase();
    set_curve(1'b1, 1'b0, 8'd127, 16'd0, 16'd0);
    put_pix(~OpMeasure, 8'h80, 8'h00, 8'h00, 8'h00, 1'b0);
    put_pix(~OpMeasure, 8'h7F, 8'hFF, 8'hFF, 8'hFF, 1'b1);
    drain_phase();
    set_curve(1'b1, 1'b0, 8'd100, 16'd16384, 16'd16384);
    put_pix(~OpMeasure, 8'h01, 8'h00, 8'h00, 8'h00, 1'b0);
    put_pix(~OpMeasure, 8'h02, 8'hFF, 8'hFF, 8'hFF, 1'b1);
    drain_phase();
    set_curve(1'b1, 1'b0, 8'd255, 16'hC000, 16'hC000);
    put_pix(~OpMeasure, 8'h03, 8'hFF, 8'hFF, 8'hFF, 1'b0);
    put_pix(~OpMeasure, 8'h04, 8'h10, 8'h20, 8'h30, 1'b1);
    drain_phase();
    set_curve(1'b1, 1'b0, 8'd0, 16'h7FFF, 16'h8000);
    put_pix(~OpMeasure, 8'h05, 8'h00, 8'h00, 8'h00, 1'b0);
    put_pix(~OpMeasure, 8'h06, 8'h55, 8'hAA, 8'h55, 1'b1);
    drain_phase();
    set_curve(1'b1, 1'b1, 8'd0, 16'd3000, 16'd16000);
    put_pix(OpMeasure, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
    put_pix(~OpMeasure, 8'h07, 8'h80, 8'h80, 8'h80, 1'b0);
    put_pix(~OpMeasure, 8'h08, 8'hFF, 8'hFF, 8'hFF, 1'b1);
    drain_phase();

    // Random: mostly measure then adjust passes under varied settings
    for (int ph = 0; ph < 40; ph++) begin
      quiet_mode = (ph >= 18 && ph < 22);
      br = $urandom_range(3) == 0 ? 16'(int'($urandom_range(32768)) - 16384)
                                  : 16'($urandom);
      ct = $urandom_range(3) == 0 ? 16'(int'($urandom_range(32768)) - 16384)
                                  : 16'($urandom);
      if (ph % 10 == 0) ct = 16'd16384;
      if (ph % 10 == 1) begin br = 16'd0; ct = 16'd0; end
      set_curve($urandom_range(5) != 0, 1'($urandom_range(1)), 8'($urandom), br, ct);
      for (int k = 0; k < 3; k++)
        queue_passes($urandom_range(1, 12), $urandom_range(1, 12), ph % 4 == 0);
      // Noise: stray adjust and measure pixels
      for (int k = 0; k < 2; k++)
        pending_pix_q.push_back(rand_pix(1'($urandom_range(1)), 1'($urandom_range(1))));
      drain_phase();
    end

    if (err_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Hard stop well past the slowest correct run
  initial begin
    #20ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/gtca_pkg.sv
rtl/core/gtca_front.sv
rtl/core/gtca_div.sv
rtl/core/gtca_back.sv
rtl/core/gray_tone_curve_adjust_core.sv
tb/tb_top.sv
